@@ hdl/amsc_pkg.sv @@
// ----------------------------------------------------------------------------
// amsc_pkg
// Shared types and constants for the accelerometer magnitude step counter.
// ----------------------------------------------------------------------------
package amsc_pkg;

  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned RootSteps     = 16;

  localparam logic [8:0]  GainOne       = 9'd256;
  localparam logic [8:0]  GainReset     = 9'd51;
  localparam logic [15:0] ThreshReset   = 16'd4915;
  localparam logic [15:0] CooldownReset = 16'd300;
  localparam logic [24:0] FilterReset   = 25'(4096 << 8);
  localparam logic [24:0] FilterMax     = '1;
  localparam logic [31:0] RootBitInit   = 32'h4000_0000;

  typedef enum logic [1:0] {
    CFG_GAIN     = 2'd0,
    CFG_THRESH   = 2'd1,
    CFG_COOLDOWN = 2'd2
  } cfg_idx_e;

  typedef enum logic [0:0] {
    ACT_SAMPLE = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQUARE,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROOT,
    B_MULT,
    B_ADD,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic [8:0]  gain;
    logic [15:0] thresh;
    logic [15:0] cooldown;
  } cfg_t;

  // one classified request as it sits in the queue
  typedef struct packed {
    action_e     action;
    logic [31:0] sum_sq;
    logic [31:0] time_ms;
  } qent_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ hdl/amsc_front.sv @@
// ----------------------------------------------------------------------------
// amsc_front
// Accepts requests, sorts clears from samples and forms x*x + y*y + z*z with
// one shared multiplier, then pushes the request into the queue.
// ----------------------------------------------------------------------------
module amsc_front
  import amsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic        [31:0] time_ms_i,
  input  q_stat_t            q_stat_i,
  output logic               push_o,
  output qent_t              push_data_o
);

  front_state_e       state_q, state_d;
  logic [1:0]         axis_q, axis_d;
  logic               action_q;
  logic signed [15:0] x_q, y_q, z_q;
  logic [31:0]        time_q;
  logic [31:0]        sum_q, sum_d;
  logic signed [15:0] operand;
  logic signed [31:0] square;
  logic               accept;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    case (axis_q)
      2'd0:    operand = x_q;
      2'd1:    operand = y_q;
      default: operand = z_q;
    endcase
  end

  assign square = 32'(operand) * 32'(operand);

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    sum_d   = sum_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          axis_d  = 2'd0;
          sum_d   = '0;
          state_d = (action_i == ACT_CLEAR) ? F_PUSH : F_SQUARE;
        end
      end
      F_SQUARE: begin
        sum_d  = sum_q + square;
        axis_d = axis_q + 2'd1;
        if (axis_q == 2'd2) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat_i.full) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign push_data_o = '{action: action_e'(action_q), sum_sq: sum_q, time_ms: time_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (accept) begin
      action_q <= action_i;
      x_q      <= accel_x_i;
      y_q      <= accel_y_i;
      z_q      <= accel_z_i;
      time_q   <= time_ms_i;
    end
  end

endmodule

@@ hdl/amsc_queue.sv @@
// ----------------------------------------------------------------------------
// amsc_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module amsc_queue
  import amsc_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  qent_t   push_data_i,
  input  logic    pop_i,
  output qent_t   pop_data_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  qent_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntFull);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/amsc_back.sv @@
// ----------------------------------------------------------------------------
// amsc_back
// Executes queued requests: bit-pair square root, low-pass filter update,
// step decision and the registered result.
// ----------------------------------------------------------------------------
module amsc_back
  import amsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  q_stat_t     q_stat_i,
  input  qent_t       pop_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        step_seen_o,
  output logic [31:0] total_steps_o,
  output logic [15:0] smoothed_magnitude_o
);

  localparam int unsigned IterW = $clog2(RootSteps);
  localparam logic [IterW-1:0] IterLast = IterW'(RootSteps - 1);

  back_state_e        state_q, state_d;
  action_e            action_q;
  logic [31:0]        time_q;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        root_q, root_d;
  logic [31:0]        bit_q, bit_d;
  logic [IterW-1:0]   iter_q, iter_d;
  logic signed [36:0] prod_q, prod_d;
  logic [24:0]        filt_q, filt_d;
  logic [31:0]        stamp_q, stamp_d;
  logic [31:0]        total_q, total_d;
  logic               out_valid_q, out_valid_d;
  logic               seen_q, seen_d;
  logic [31:0]        out_total_q, out_total_d;
  logic [15:0]        smooth_q, smooth_d;

  logic [31:0]        trial;
  logic [8:0]         alpha;
  logic signed [26:0] diff;
  logic signed [9:0]  alpha_s;
  logic signed [36:0] delta;
  logic signed [37:0] filt_sum;
  logic               load_ok;
  logic               hit;

  assign trial   = root_q + bit_q;
  assign alpha   = (cfg_i.gain > GainOne) ? GainOne : cfg_i.gain;
  assign alpha_s = $signed({1'b0, alpha});
  assign diff    = $signed({3'b000, root_q[15:0], 8'h00}) - $signed({2'b00, filt_q});
  assign delta   = prod_q >>> 8;  // floor division by 256
  assign filt_sum = $signed({13'd0, filt_q}) + 38'(delta);
  assign load_ok = !out_valid_q || !out_stall_i;
  assign hit     = (filt_q > {1'b0, cfg_i.thresh, 8'h00}) &&
                   ((time_q - stamp_q) > {16'd0, cfg_i.cooldown});

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    root_d      = root_q;
    bit_d       = bit_q;
    iter_d      = iter_q;
    prod_d      = prod_q;
    filt_d      = filt_q;
    stamp_d     = stamp_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    seen_d      = seen_q;
    out_total_d = out_total_q;
    smooth_d    = smooth_q;
    pop_o       = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          rem_d   = pop_data_i.sum_sq;
          root_d  = '0;
          bit_d   = RootBitInit;
          iter_d  = '0;
          state_d = (pop_data_i.action == ACT_CLEAR) ? B_DONE : B_ROOT;
        end
      end
      B_ROOT: begin
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        iter_d = iter_q + 1'b1;
        if (iter_q == IterLast) begin
          state_d = B_MULT;
        end
      end
      B_MULT: begin
        prod_d  = 37'(diff) * 37'(alpha_s);
        state_d = B_ADD;
      end
      B_ADD: begin
        if (filt_sum[37]) begin
          filt_d = '0;
        end else if (|filt_sum[36:25]) begin
          filt_d = FilterMax;
        end else begin
          filt_d = filt_sum[24:0];
        end
        state_d = B_DONE;
      end
      B_DONE: begin
        if (load_ok) begin
          if (action_q == ACT_CLEAR) begin
            total_d = '0;
            seen_d  = 1'b0;
          end else if (hit) begin
            total_d = total_q + 32'd1;
            stamp_d = time_q;
            seen_d  = 1'b1;
          end else begin
            seen_d  = 1'b0;
          end
          out_total_d = total_d;
          smooth_d    = filt_q[24] ? 16'hFFFF : filt_q[23:8];
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      iter_q      <= '0;
      filt_q      <= FilterReset;
      stamp_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      filt_q      <= filt_d;
      stamp_q     <= stamp_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    root_q      <= root_d;
    bit_q       <= bit_d;
    prod_q      <= prod_d;
    seen_q      <= seen_d;
    out_total_q <= out_total_d;
    smooth_q    <= smooth_d;
    if (pop_o) begin
      action_q <= pop_data_i.action;
      time_q   <= pop_data_i.time_ms;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign step_seen_o          = seen_q;
  assign total_steps_o        = out_total_q;
  assign smoothed_magnitude_o = smooth_q;

endmodule

@@ hdl/accel_magnitude_step_counter.sv @@
// ----------------------------------------------------------------------------
// accel_magnitude_step_counter
// Step detector on accelerometer magnitude with low-pass filtering.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid_i/in_stall_o  | action, accel_x/y/z, time_ms
//  out     | out_valid_o/out_stall_i| step_seen, total_steps,
//          |                        | smoothed_magnitude
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  A sample passes the front's squaring, the queue, the back part's 16-step
//  square root loop, filter multiply and add, and the result register; the
//  back part pops a new request only after loading the result. A clear
//  skips squaring, root and filter. The front holds off new requests while
//  it squares a sample and pushes a request, longer while the queue is full.
//  Reset restores the filter to 1 g and zeroes count and stamp.
//  A stalled result holds the back part in its final state.
// ----------------------------------------------------------------------------
module accel_magnitude_step_counter
  import amsc_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic        [31:0] time_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               step_seen_o,
  output logic        [31:0] total_steps_o,
  output logic        [15:0] smoothed_magnitude_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [1:0]  cfg_index_i,
  input  logic        [15:0] cfg_data_i
);

  cfg_t    cfg_q;
  q_stat_t q_stat;
  logic    push, pop;
  qent_t   push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain     <= GainReset;
      cfg_q.thresh   <= ThreshReset;
      cfg_q.cooldown <= CooldownReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN:     cfg_q.gain     <= cfg_data_i[8:0];
        CFG_THRESH:   cfg_q.thresh   <= cfg_data_i;
        CFG_COOLDOWN: cfg_q.cooldown <= cfg_data_i;
        default:      ;  // unmapped index, write dropped
      endcase
    end
  end

  amsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .time_ms_i   (time_ms_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  amsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  amsc_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .q_stat_i             (q_stat),
    .pop_data_i           (pop_data),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .step_seen_o          (step_seen_o),
    .total_steps_o        (total_steps_o),
    .smoothed_magnitude_o (smoothed_magnitude_o)
  );

endmodule

@@ hdl/amsc_checker.sv @@
// ----------------------------------------------------------------------------
// amsc_checker
// Port-level checks on the step counter, bound to the top level.
// ----------------------------------------------------------------------------
module amsc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               step_seen_o,
  input logic        [31:0] total_steps_o,
  input logic        [15:0] smoothed_magnitude_o
);

  // the front is busy after taking any request, so it never takes back-to-back requests
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front took back-to-back requests");

  // filtered value never exceeds the largest possible magnitude
  a_smooth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> smoothed_magnitude_o <= 16'd56755)
    else $error("smoothed magnitude out of range");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(step_seen_o) && $stable(total_steps_o) && $stable(smoothed_magnitude_o))
    else $error("result changed while stalled");

endmodule

bind accel_magnitude_step_counter amsc_checker u_amsc_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the accelerometer step counter against a predictor of its own. It
// covers magnitude extremes, the cooldown boundary, timestamp wrap, clears
// and gain saturation, then runs simulated walking with noise under a range
// of register settings, with random gaps and back-pressure on both sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import amsc_pkg::*;

  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 40;
  localparam int PhaseItems   = 230;

  typedef struct {
    action_e            act;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic        [31:0] t;
  } sample_req_t;

  typedef struct packed {
    logic        seen;
    logic [31:0] total;
    logic [15:0] smooth;
  } step_report_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               action_i    = 1'b0;
  logic signed [15:0] accel_x_i   = '0;
  logic signed [15:0] accel_y_i   = '0;
  logic signed [15:0] accel_z_i   = '0;
  logic        [31:0] time_ms_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               step_seen_o;
  logic        [31:0] total_steps_o;
  logic        [15:0] smoothed_magnitude_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic        [1:0]  cfg_index_i = '0;
  logic        [15:0] cfg_data_i  = '0;

  accel_magnitude_step_counter dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state, reset values
  logic [8:0]  gain_cfg     = GainReset;
  logic [15:0] thresh_cfg   = ThreshReset;
  logic [15:0] cooldown_cfg = CooldownReset;
  logic [24:0] flt_q8       = FilterReset;
  logic [31:0] last_stamp   = '0;
  logic [31:0] steps_pred   = '0;

  sample_req_t  pend_q[$];
  step_report_t report_q[$];
  sample_req_t  cur_req;

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int err_cnt      = 0;
  int quiet_cycles = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  bit gaps_on      = 1'b1;
  bit stall_on     = 1'b1;

  logic [31:0] walk_ms  = '0;
  int          gait_pos = 0;

  function automatic step_report_t predict_step(sample_req_t r);
    step_report_t res;
    longint       sum_sq;
    longint       delta;
    longint       nxt;
    logic [15:0]  root;
    logic [16:0]  trial;
    logic [16:0]  whole;
    logic [31:0]  alpha;
    logic [31:0]  elapsed;
    res.seen = 1'b0;
    if (r.act == ACT_CLEAR) begin
      steps_pred = '0;
    end else begin
      sum_sq = longint'(r.x) * longint'(r.x) + longint'(r.y) * longint'(r.y) +
               longint'(r.z) * longint'(r.z);
      // floor square root, one bit at a time from the top
      root = '0;
      for (int b = 15; b >= 0; b--) begin
        trial = {1'b0, root} | (17'd1 << b);
        if (longint'(trial) * longint'(trial) <= sum_sq) root = trial[15:0];
      end
      alpha = (gain_cfg > GainOne) ? 32'(GainOne) : 32'(gain_cfg);
      delta = (longint'(root) << 8) - longint'(flt_q8);
      nxt = longint'(flt_q8) + ((longint'(alpha) * delta) >>> 8);
      if (nxt < 0) nxt = 0;
      if (nxt > longint'(FilterMax)) nxt = longint'(FilterMax);
      flt_q8 = nxt[24:0];
      elapsed = r.t - last_stamp;
      if (flt_q8 > {thresh_cfg, 8'd0} && elapsed > 32'(cooldown_cfg)) begin
        steps_pred = steps_pred + 32'd1;
        last_stamp = r.t;
        res.seen = 1'b1;
      end
    end
    whole = flt_q8[24:8];
    res.smooth = whole[16] ? 16'hFFFF : whole[15:0];
    res.total = steps_pred;
    return res;
  endfunction

  task automatic add_sample(int x, int y, int z, logic [31:0] t);
    sample_req_t r;
    r.act = ACT_SAMPLE;
    r.x = 16'(x);
    r.y = 16'(y);
    r.z = 16'(z);
    r.t = t;
    pend_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic add_clear();
    sample_req_t r;
    r.act = ACT_CLEAR;
    r.x = 16'($urandom);
    r.y = 16'($urandom);
    r.z = 16'($urandom);
    r.t = $urandom;
    pend_q.push_back(r);
    queued_cnt++;
  endtask

  // mostly gait-like samples, some raw noise, a few clears
  task automatic add_walk(int n);
    int r;
    int z;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        add_clear();
      end else if (r < 12) begin
        if ($urandom_range(0, 1) != 0) walk_ms = $urandom;
        add_sample(int'($urandom), int'($urandom), int'($urandom), walk_ms);
      end else begin
        walk_ms = walk_ms + $urandom_range(5, 60);
        gait_pos = (gait_pos + 1) % 12;
        if (gait_pos < 3) begin
          z = int'($urandom_range(7000, 16000));
          if ($urandom_range(0, 1) != 0) z = -z;
        end else begin
          z = 4096 + int'($urandom_range(0, 2400)) - 1200;
        end
        add_sample(int'($urandom_range(0, 3000)) - 1500,
                   int'($urandom_range(0, 3000)) - 1500, z, walk_ms);
      end
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_GAIN:     gain_cfg = data[8:0];
      CFG_THRESH:   thresh_cfg = data;
      CFG_COOLDOWN: cooldown_cfg = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    wait (accepted_cnt == queued_cnt && checked_cnt == queued_cnt);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        report_q.push_back(predict_step(cur_req));
        accepted_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pend_q.size() != 0) begin
          cur_req = pend_q.pop_front();
          action_i   <= cur_req.act;
          accel_x_i  <= cur_req.x;
          accel_y_i  <= cur_req.y;
          accel_z_i  <= cur_req.z;
          time_ms_i  <= cur_req.t;
          in_valid_i <= 1'b1;
          gap_left = gaps_on ? int'($urandom_range(0, 4)) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor; each result is held off for its drawn stall count
  always @(posedge clk_i or negedge rst_ni) begin
    step_report_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        checked_cnt++;
        if (report_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result seen=%0d total=%0d mag=%0d", $time,
                   step_seen_o, total_steps_o, smoothed_magnitude_o);
        end else begin
          want = report_q.pop_front();
          if (step_seen_o !== want.seen) begin
            err_cnt++;
            $display("%0t: step_seen expected %0d actual %0d", $time,
                     want.seen, step_seen_o);
          end
          if (total_steps_o !== want.total) begin
            err_cnt++;
            $display("%0t: total_steps expected %0d actual %0d", $time,
                     want.total, total_steps_o);
          end
          if (smoothed_magnitude_o !== want.smooth) begin
            err_cnt++;
            $display("%0t: smoothed_magnitude expected %0d actual %0d", $time,
                     want.smooth, smoothed_magnitude_o);
          end
        end
        stall_left = stall_on ? int'($urandom_range(0, 4)) : 0;
      end else if (stall_left != 0 && out_valid_o) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [15:0] g;
    logic [15:0] th;
    logic [15:0] cd;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes with reset settings, filter pushed well above threshold
    add_sample(0, 0, 0, 32'd0);
    add_sample(-32768, -32768, -32768, 32'd10);
    add_sample(32767, 32767, 32767, 32'd20);
    add_sample(32767, -32768, 0, 32'd301);
    add_sample(-32768, 32767, 1, 32'd601);     // gap equals cooldown: no step
    add_sample(20000, -20000, 20000, 32'd602); // one past cooldown: step
    add_clear();
    add_sample(30000, 30000, -30000, 32'hFFFF_FFF0);
    add_sample(30000, -30000, 30000, 32'h0000_0100); // wrapped, too soon
    add_sample(-30000, 30000, 30000, 32'h0000_0200); // wrapped, step
    add_sample(1, 1, 1, 32'h0000_0300);
    // let the filter decay below threshold with cooldown long over
    for (int k = 1; k <= 10; k++) add_sample(0, 0, 0, 32'h0000_0200 + 32'(k * 1000));
    add_clear();
    walk_ms = $urandom;
    add_walk(PhaseItems);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin g = 16'hFFFF; th = 16'd0; cd = 16'd0; end
        1: begin g = 16'd0; th = 16'hFFFF; cd = 16'hFFFF; end
        2: begin g = 16'd256; th = 16'd8000; cd = 16'd100; end
        3: begin g = 16'd1; th = 16'd3000; cd = 16'd50; end
        4: begin
          g  = 16'($urandom_range(0, 300));
          th = 16'($urandom_range(3000, 9000));
          cd = 16'($urandom_range(0, 400));
        end
        default: begin g = 16'(GainReset); th = ThreshReset; cd = CooldownReset; end
      endcase
      write_reg(CFG_GAIN, g);
      write_reg(CFG_THRESH, th);
      write_reg(CFG_COOLDOWN, cd);
      gaps_on  = (p % 3 != 0);
      stall_on = (p % 3 != 1);
      add_walk(PhaseItems);
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (report_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
